// ----- hdl/assert_macros.svh -----
// Assertion macros used by the decoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define GLD_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define GLD_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that an antecedent implies a consequent in the next cycle.
`define GLD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/gld_pkg.sv -----
// Package: constants, codes and types of the GIF LZW decoder.
package gld_pkg;
	localparam int TABLE_ENTRIES = 4096;
	localparam int IDX_W = 12;
	localparam int MAX_WIDTH = 12;
	localparam int BIT_BUFFER_BITS = 32;
	localparam logic [31:0] MAX_PIXELS = 32'd4294836225;

	localparam logic CMD_PUSH = 1'b0;
	localparam logic CMD_PULL = 1'b1;

	localparam logic [1:0] REG_MIN_CODE = 2'd0;
	localparam logic [1:0] REG_COLOR_BITS = 2'd1;
	localparam logic [1:0] REG_PIXEL_COUNT = 2'd2;

	localparam logic [3:0] ST_PIXEL = 4'd0;
	localparam logic [3:0] ST_END = 4'd1;
	localparam logic [3:0] ST_GAP = 4'd2;
	localparam logic [3:0] ST_NOT_NEXT = 4'd3;
	localparam logic [3:0] ST_NO_PRIOR = 4'd4;
	localparam logic [3:0] ST_OVERFLOW = 4'd5;
	localparam logic [3:0] ST_FULL = 4'd6;
	localparam logic [3:0] ST_NO_DATA = 4'd7;
	localparam logic [3:0] ST_SHORT = 4'd8;
	localparam logic [3:0] ST_TRAILING = 4'd9;
	localparam logic [3:0] ST_BAD_CFG = 4'd10;
	localparam logic [3:0] ST_OVERRUN = 4'd11;

	typedef struct packed {
		logic en;
		logic [IDX_W-1:0] addr;
		logic [IDX_W-1:0] prefix;
		logic [7:0] suffix;
		logic [IDX_W-1:0] length;
	} dict_wr_t;

	typedef struct packed {
		logic [IDX_W-1:0] prefix;
		logic [7:0] suffix;
		logic [IDX_W-1:0] length;
	} dict_rd_t;
endpackage

// ----- hdl/gld_in_if.sv -----
// Input channel: push byte or pull index commands.
interface gld_in_if;
	logic valid;
	logic ready;
	logic command;
	logic [7:0] data_byte;
	logic final_byte;
	modport source(output valid, command, data_byte, final_byte, input ready);
	modport sink(input valid, command, data_byte, final_byte, output ready);
endinterface

// ----- hdl/gld_out_if.sv -----
// Output channel: decoded index and status words.
interface gld_out_if;
	logic valid;
	logic ready;
	logic [7:0] pixel_index;
	logic [3:0] status;
	logic last;
	modport source(output valid, pixel_index, status, last, input ready);
	modport sink(input valid, pixel_index, status, last, output ready);
endinterface

// ----- hdl/gld_cfg_if.sv -----
// Configuration write channel.
interface gld_cfg_if;
	logic valid;
	logic ready;
	logic [1:0] index;
	logic [31:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// ----- hdl/gif_lzw_decoder.sv -----
// GIF LZW decoder: push bytes, pull one colour index per pull command.
//
// Channels: din takes commands (push one code byte, or pull one index),
// dout returns at most one word per command, cfg writes the three setup
// registers (minimum code size, colour bits, pixel count) before the first
// pull; later writes are dropped.
// One command is in flight at a time. din is ready only when the block is
// idle and the output register is empty. A pull that pops a pending index
// passes through the loop and pop states. A pull that decodes a new code
// reads the code, fetches the lengths, then walks the prefix chain through
// the dictionary memory (one registered read per step) and adds the new
// entry before the pop; a clear code sends the loop back for the next code.
// Reset clears all control state; dictionary and stack memories are not
// cleared and every entry is written before it is read.
// A stalled receiver holds the result word in the output register and the
// block takes no further command until it is taken.
// Errors are sticky: every later pull returns the same status with last set.
`include "assert_macros.svh"
module gif_lzw_decoder #(
	parameter int BIT_BUFFER_BITS = gld_pkg::BIT_BUFFER_BITS
) (
	input logic clk,
	input logic arst_n,
	gld_cfg_if.sink cfg,
	gld_in_if.sink din,
	gld_out_if.source dout
);
	localparam int HB = $clog2(BIT_BUFFER_BITS + 1);
	localparam int IW = gld_pkg::IDX_W;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_LOOP = 4'd1;
	localparam logic [3:0] S_POP = 4'd2;
	localparam logic [3:0] S_LENP = 4'd3;
	localparam logic [3:0] S_LENC = 4'd4;
	localparam logic [3:0] S_WALK = 4'd5;
	localparam logic [3:0] S_WALK2 = 4'd6;
	localparam logic [3:0] S_FIX = 4'd7;
	localparam logic [3:0] S_ADD = 4'd8;

	logic [3:0] state_q;
	logic [3:0] mcs_q, cb_q;
	logic [31:0] pc_q, pd_q;
	logic [BIT_BUFFER_BITS-1:0] buf_q;
	logic [HB-1:0] bits_q;
	logic [3:0] cw_q;
	logic [IW:0] ne_q;
	logic [IW-1:0] prev_q, code_q, walk_q;
	logic [IW:0] level_q;
	logic [IW-1:0] lenp_q;
	logic [7:0] root_q;
	logic prev_valid_q, final_q, done_q, failed_q, started_q, known_q;
	logic [3:0] err_q;
	logic out_valid_q, out_last_q;
	logic [7:0] out_pix_q;
	logic [3:0] out_st_q;

	logic [7:0] stack_mem [gld_pkg::TABLE_ENTRIES];
	logic [7:0] stack_rd;
	logic stk_we;
	logic [IW-1:0] stk_waddr, stk_raddr;
	logic [7:0] stk_wdata;

	logic [IW-1:0] dict_raddr;
	gld_pkg::dict_wr_t dict_wr;
	gld_pkg::dict_rd_t dict_rd;

	logic [IW-1:0] clear_c, roots_c, first_c, end_c, code_c, lenc_c, len_c;
	logic [3:0] cw_n;
	logic [IW:0] code_mask;
	logic [HB-1:0] bits_left;
	logic known_c, cfg_bad, accept;
	logic [32:0] sum_c;

	gld_dict u_dict (
		.clk(clk),
		.raddr(dict_raddr),
		.wr(dict_wr),
		.rd(dict_rd)
	);

	always_ff @(posedge clk) begin
		if (stk_we) begin
			stack_mem[stk_waddr] <= stk_wdata;
		end
		stack_rd <= stack_mem[stk_raddr];
	end

	assign cfg.ready = 1'b1;
	assign din.ready = (state_q == S_IDLE) && !out_valid_q;
	assign accept = din.valid && din.ready;
	assign dout.valid = out_valid_q;
	assign dout.pixel_index = out_pix_q;
	assign dout.status = out_st_q;
	assign dout.last = out_last_q;

	always_comb begin
		clear_c = IW'(1) << mcs_q;
		roots_c = IW'(1) << cb_q;
		first_c = clear_c + IW'(2);
		end_c = clear_c + IW'(1);
		cw_n = ((ne_q >= ((IW+1)'(1) << cw_q)) && (cw_q < 4'(gld_pkg::MAX_WIDTH)))
			? cw_q + 4'd1 : cw_q;
		code_mask = (IW+1)'(((IW+1)'(1) << cw_n) - (IW+1)'(1));
		code_c = buf_q[IW-1:0] & code_mask[IW-1:0];
		bits_left = bits_q - HB'(cw_n);
		known_c = (code_c < roots_c) || ({1'b0, code_c} < ne_q);
		lenc_c = (code_q < clear_c) ? IW'(1) : dict_rd.length;
		len_c = known_q ? lenc_c : lenp_q + IW'(1);
		sum_c = {1'b0, pd_q} + 33'(len_c);
		cfg_bad = (mcs_q < 4'd1) || (mcs_q > 4'd11) || (cb_q < 4'd1) || (cb_q > 4'd8)
			|| (cb_q > mcs_q) || (pc_q < 32'd2) || (pc_q > gld_pkg::MAX_PIXELS);
	end

	always_comb begin
		dict_raddr = walk_q;
		unique case (state_q)
			S_LOOP: dict_raddr = prev_q;
			S_LENP: dict_raddr = code_q;
			default: dict_raddr = walk_q;
		endcase
		stk_raddr = IW'(level_q - (IW+1)'(1));
		stk_we = 1'b0;
		stk_waddr = level_q[IW-1:0];
		stk_wdata = walk_q[7:0];
		if (state_q == S_WALK && walk_q < first_c) begin
			stk_we = 1'b1;
		end else if (state_q == S_WALK2) begin
			stk_we = 1'b1;
			stk_wdata = dict_rd.suffix;
		end else if (state_q == S_FIX) begin
			stk_we = 1'b1;
			stk_waddr = '0;
			stk_wdata = root_q;
		end
		dict_wr.en = (state_q == S_ADD) && prev_valid_q
			&& (ne_q < (IW+1)'(gld_pkg::TABLE_ENTRIES));
		dict_wr.addr = ne_q[IW-1:0];
		dict_wr.prefix = prev_q;
		dict_wr.suffix = root_q;
		dict_wr.length = lenp_q + IW'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			mcs_q <= 4'd8;
			cb_q <= 4'd8;
			pc_q <= 32'd2;
			pd_q <= '0;
			buf_q <= '0;
			bits_q <= '0;
			cw_q <= 4'd9;
			ne_q <= (IW+1)'(258);
			prev_valid_q <= 1'b0;
			final_q <= 1'b0;
			done_q <= 1'b0;
			failed_q <= 1'b0;
			started_q <= 1'b0;
			err_q <= gld_pkg::ST_PIXEL;
			level_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && dout.ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg.valid && !started_q) begin
				unique case (cfg.index)
					gld_pkg::REG_MIN_CODE: mcs_q <= cfg.data[3:0];
					gld_pkg::REG_COLOR_BITS: cb_q <= cfg.data[3:0];
					gld_pkg::REG_PIXEL_COUNT: pc_q <= cfg.data;
					default: ;
				endcase
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept && din.command == gld_pkg::CMD_PUSH) begin
						if (failed_q || done_q) begin
						end else if (final_q || (({1'b0, bits_q} + (HB+1)'(8))
							> (HB+1)'(BIT_BUFFER_BITS))) begin
							failed_q <= 1'b1;
							err_q <= gld_pkg::ST_OVERRUN;
							out_valid_q <= 1'b1;
							out_pix_q <= '0;
							out_st_q <= gld_pkg::ST_OVERRUN;
							out_last_q <= 1'b1;
						end else begin
							buf_q <= buf_q | (BIT_BUFFER_BITS'(din.data_byte) << bits_q);
							bits_q <= bits_q + HB'(8);
							final_q <= final_q | din.final_byte;
						end
					end else if (accept) begin
						if (failed_q) begin
							out_valid_q <= 1'b1;
							out_pix_q <= '0;
							out_st_q <= err_q;
							out_last_q <= 1'b1;
						end else if (done_q) begin
							out_valid_q <= 1'b1;
							out_pix_q <= '0;
							out_st_q <= gld_pkg::ST_END;
							out_last_q <= 1'b1;
						end else if (!started_q && cfg_bad) begin
							failed_q <= 1'b1;
							err_q <= gld_pkg::ST_BAD_CFG;
							out_valid_q <= 1'b1;
							out_pix_q <= '0;
							out_st_q <= gld_pkg::ST_BAD_CFG;
							out_last_q <= 1'b1;
						end else begin
							if (!started_q) begin
								started_q <= 1'b1;
								cw_q <= mcs_q + 4'd1;
								ne_q <= {1'b0, first_c};
								prev_valid_q <= 1'b0;
							end
							state_q <= S_LOOP;
						end
					end
				end
				S_LOOP: begin
					if (level_q != '0) begin
						level_q <= level_q - (IW+1)'(1);
						state_q <= S_POP;
					end else begin
						if (bits_q < HB'(cw_n)) begin
							cw_q <= cw_n;
							state_q <= S_IDLE;
							if (final_q) begin
								failed_q <= 1'b1;
								err_q <= gld_pkg::ST_NO_DATA;
								out_valid_q <= 1'b1;
								out_pix_q <= '0;
								out_st_q <= gld_pkg::ST_NO_DATA;
								out_last_q <= 1'b1;
							end
						end else begin
							cw_q <= (code_c == clear_c) ? mcs_q + 4'd1 : cw_n;
							buf_q <= buf_q >> cw_n;
							bits_q <= bits_left;
							code_q <= code_c;
							known_q <= known_c;
							if (code_c >= roots_c && code_c < clear_c) begin
								state_q <= S_IDLE;
								failed_q <= 1'b1;
								err_q <= gld_pkg::ST_GAP;
								out_valid_q <= 1'b1;
								out_pix_q <= '0;
								out_st_q <= gld_pkg::ST_GAP;
								out_last_q <= 1'b1;
							end else if (code_c == clear_c) begin
								ne_q <= {1'b0, first_c};
								prev_valid_q <= 1'b0;
							end else if (code_c == end_c) begin
								state_q <= S_IDLE;
								out_valid_q <= 1'b1;
								out_pix_q <= '0;
								out_last_q <= 1'b1;
								if (!final_q || bits_left >= HB'(8)) begin
									failed_q <= 1'b1;
									err_q <= gld_pkg::ST_TRAILING;
									out_st_q <= gld_pkg::ST_TRAILING;
								end else if (pd_q != pc_q) begin
									failed_q <= 1'b1;
									err_q <= gld_pkg::ST_SHORT;
									out_st_q <= gld_pkg::ST_SHORT;
								end else begin
									done_q <= 1'b1;
									out_st_q <= gld_pkg::ST_END;
								end
							end else if (known_c) begin
								state_q <= S_LENP;
							end else if (!prev_valid_q) begin
								state_q <= S_IDLE;
								failed_q <= 1'b1;
								err_q <= gld_pkg::ST_NO_PRIOR;
								out_valid_q <= 1'b1;
								out_pix_q <= '0;
								out_st_q <= gld_pkg::ST_NO_PRIOR;
								out_last_q <= 1'b1;
							end else if ({1'b0, code_c} != ne_q) begin
								state_q <= S_IDLE;
								failed_q <= 1'b1;
								err_q <= gld_pkg::ST_NOT_NEXT;
								out_valid_q <= 1'b1;
								out_pix_q <= '0;
								out_st_q <= gld_pkg::ST_NOT_NEXT;
								out_last_q <= 1'b1;
							end else begin
								state_q <= S_LENP;
							end
						end
					end
				end
				S_POP: begin
					pd_q <= pd_q + 32'd1;
					out_valid_q <= 1'b1;
					out_pix_q <= stack_rd;
					out_st_q <= gld_pkg::ST_PIXEL;
					out_last_q <= (pd_q + 32'd1) == pc_q;
					state_q <= S_IDLE;
				end
				S_LENP: begin
					lenp_q <= (prev_q < clear_c) ? IW'(1) : dict_rd.length;
					state_q <= S_LENC;
				end
				S_LENC: begin
					if (sum_c > {1'b0, pc_q}) begin
						state_q <= S_IDLE;
						failed_q <= 1'b1;
						err_q <= gld_pkg::ST_OVERFLOW;
						out_valid_q <= 1'b1;
						out_pix_q <= '0;
						out_st_q <= gld_pkg::ST_OVERFLOW;
						out_last_q <= 1'b1;
					end else if (!known_q && ne_q >= (IW+1)'(gld_pkg::TABLE_ENTRIES)) begin
						state_q <= S_IDLE;
						failed_q <= 1'b1;
						err_q <= gld_pkg::ST_FULL;
						out_valid_q <= 1'b1;
						out_pix_q <= '0;
						out_st_q <= gld_pkg::ST_FULL;
						out_last_q <= 1'b1;
					end else begin
						walk_q <= known_q ? code_q : prev_q;
						level_q <= known_q ? '0 : (IW+1)'(1);
						state_q <= S_WALK;
					end
				end
				S_WALK: begin
					if (walk_q >= first_c) begin
						state_q <= S_WALK2;
					end else begin
						level_q <= level_q + (IW+1)'(1);
						root_q <= walk_q[7:0];
						state_q <= known_q ? S_ADD : S_FIX;
					end
				end
				S_WALK2: begin
					level_q <= level_q + (IW+1)'(1);
					walk_q <= dict_rd.prefix;
					state_q <= S_WALK;
				end
				S_FIX: begin
					state_q <= S_ADD;
				end
				S_ADD: begin
					if (dict_wr.en) begin
						ne_q <= ne_q + (IW+1)'(1);
					end
					prev_q <= code_q;
					prev_valid_q <= 1'b1;
					state_q <= S_LOOP;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`GLD_ASSERT_ALWAYS(a_bits_bound, bits_q <= HB'(BIT_BUFFER_BITS), "bit count overflow")
	`GLD_ASSERT_ALWAYS(a_level_bound, level_q <= (IW+1)'(gld_pkg::TABLE_ENTRIES), "stack overflow")
	`GLD_ASSERT_IMPLY(a_status_sticky, out_valid_q && out_st_q != gld_pkg::ST_PIXEL,
		failed_q || done_q, "terminal status without sticky flag")
	`GLD_ASSERT_NEXT(a_pop_emits, state_q == S_POP, out_valid_q && state_q == S_IDLE,
		"pop did not produce a word")
endmodule

// ----- hdl/gld_dict.sv -----
// Dictionary memories: prefix, suffix and length per code.
module gld_dict (
	input  logic clk,
	input  logic [gld_pkg::IDX_W-1:0] raddr,
	input  gld_pkg::dict_wr_t wr,
	output gld_pkg::dict_rd_t rd
);
	logic [gld_pkg::IDX_W-1:0] prefix_mem [gld_pkg::TABLE_ENTRIES];
	logic [7:0] suffix_mem [gld_pkg::TABLE_ENTRIES];
	logic [gld_pkg::IDX_W-1:0] length_mem [gld_pkg::TABLE_ENTRIES];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			prefix_mem[wr.addr] <= wr.prefix;
			suffix_mem[wr.addr] <= wr.suffix;
			length_mem[wr.addr] <= wr.length;
		end
		rd.prefix <= prefix_mem[raddr];
		rd.suffix <= suffix_mem[raddr];
		rd.length <= length_mem[raddr];
	end
endmodule

// ----- test/gif_lzw_decoder_test.sv -----
// Testbench of the GIF LZW decoder: an encoded image stream checked against a predictor.
`timescale 1ns / 100ps
module gif_lzw_decoder_test;
	localparam int CYCLE_LIMIT = 3000000;
	localparam int PIXELS = 1150;

	typedef struct packed {
		logic [7:0] pix;
		logic [3:0] st;
		logic last;
	} word_t;

	typedef struct {
		logic cmd;
		logic [7:0] b;
		logic fin;
		int chk;
		logic [3:0] st;
		logic last;
	} row_t;

	localparam int CHK_MODEL = 0;
	localparam int CHK_NONE = 1;
	localparam int CHK_STATUS = 2;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	gld_cfg_if cfg();
	gld_in_if din();
	gld_out_if dout();

	gif_lzw_decoder uut(.clk(clk), .arst_n(arst_n), .cfg(cfg), .din(din), .dout(dout));

	always #1 clk = ~clk;

	word_t expected_words[$];
	int mismatches = 0;
	int cycles = 0;
	int accepted = 0;
	int idle_mode = 0;

	// decoder state mirror
	int cfg_min = 8, cfg_color = 8;
	longint cfg_pixels = 2;
	int pfx[gld_pkg::TABLE_ENTRIES], sfx[gld_pkg::TABLE_ENTRIES];
	int lens[gld_pkg::TABLE_ENTRIES], stk[gld_pkg::TABLE_ENTRIES];
	int lvl = 0, held = 0, cw = 9, nxt = 258, prev_code = 0, err_code = 0;
	bit prev_ok = 0, final_seen = 0, done = 0, failed = 0, started = 0;
	logic [63:0] bitbuf = '0;
	longint pixels_done = 0;

	// encoder output
	logic [7:0] stream[$];
	int pixels[PIXELS];

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	always @(negedge clk)
		dout.ready <= arst_n && !(((idle_mode == 2 && $urandom_range(99) < 51) ||
			(idle_mode == 3 && $urandom_range(99) < 32)));

	always @(posedge clk)
		if (arst_n && dout.valid && dout.ready) begin
			if (expected_words.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected word: pix %0d status %0d last %0d",
						dout.pixel_index, dout.status, dout.last);
			end else begin
				word_t w;
				w = expected_words.pop_front();
				if (w.pix !== dout.pixel_index || w.st !== dout.status || w.last !== dout.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected pix %0d status %0d last %0d, got %0d %0d %0d",
							w.pix, w.st, w.last, dout.pixel_index, dout.status, dout.last);
				end
			end
		end

	function automatic void config_write(input int idx, input longint val);
		if (started)
			return;
		if (idx == gld_pkg::REG_MIN_CODE)
			cfg_min = int'(val & 15);
		else if (idx == gld_pkg::REG_COLOR_BITS)
			cfg_color = int'(val & 15);
		else if (idx == gld_pkg::REG_PIXEL_COUNT)
			cfg_pixels = val & 64'hFFFF_FFFF;
	endfunction

	function automatic void add_entry(input int p, input int ch, input int clr);
		int e;
		e = nxt & 4095;
		pfx[e] = p & 4095;
		sfx[e] = ch;
		lens[e] = ((p < clr ? 1 : lens[p & 4095]) + 1) & 16'hFFFF;
		nxt++;
	endfunction

	function automatic void unwind(input int c, input int fe);
		lvl = 0;
		while (c >= fe && lvl < gld_pkg::TABLE_ENTRIES - 1) begin
			stk[lvl++] = sfx[c & 4095];
			c = pfx[c & 4095];
		end
		stk[lvl++] = c & 255;
	endfunction

	function automatic void decode_step(input logic cmd, input logic [7:0] b, input logic fin,
		output bit has, output word_t w);
		int clr, roots, fe, c, ln, n;
		has = 0;
		w = '0;
		if (cmd == gld_pkg::CMD_PUSH) begin
			if (failed || done)
				return;
			if (final_seen || held + 8 > gld_pkg::BIT_BUFFER_BITS) begin
				failed = 1; err_code = gld_pkg::ST_OVERRUN; has = 1;
				w = {8'd0, gld_pkg::ST_OVERRUN, 1'b1};
				return;
			end
			bitbuf |= 64'(b) << held;
			held += 8;
			if (fin)
				final_seen = 1;
			return;
		end
		has = 1;
		if (failed) begin
			w = {8'd0, 4'(err_code), 1'b1};
			return;
		end
		if (done) begin
			w = {8'd0, gld_pkg::ST_END, 1'b1};
			return;
		end
		if (!started) begin
			if (cfg_min < 1 || cfg_min > 11 || cfg_color < 1 || cfg_color > 8 ||
					cfg_color > cfg_min || cfg_pixels < 2 ||
					cfg_pixels > gld_pkg::MAX_PIXELS) begin
				failed = 1; err_code = gld_pkg::ST_BAD_CFG;
				w = {8'd0, gld_pkg::ST_BAD_CFG, 1'b1};
				return;
			end
			started = 1;
			cw = cfg_min + 1;
			nxt = (1 << cfg_min) + 2;
			prev_ok = 0;
		end
		clr = 1 << cfg_min;
		roots = 1 << cfg_color;
		fe = clr + 2;
		forever begin
			if (lvl > 0) begin
				lvl--;
				pixels_done++;
				w = {8'(stk[lvl & 4095]), gld_pkg::ST_PIXEL, pixels_done == cfg_pixels};
				return;
			end
			if (nxt >= (1 << cw) && cw < gld_pkg::MAX_WIDTH)
				cw++;
			if (held < cw) begin
				if (final_seen) begin
					failed = 1; err_code = gld_pkg::ST_NO_DATA;
					w = {8'd0, gld_pkg::ST_NO_DATA, 1'b1};
				end else
					has = 0;
				return;
			end
			c = int'(bitbuf & ((64'd1 << cw) - 1));
			bitbuf >>= cw;
			held -= cw;
			err_code = 0;
			if (c >= roots && c < clr)
				err_code = gld_pkg::ST_GAP;
			else if (c == clr) begin
				nxt = fe;
				cw = cfg_min + 1;
				prev_ok = 0;
				continue;
			end else if (c == clr + 1) begin
				if (!final_seen || held >= 8)
					err_code = gld_pkg::ST_TRAILING;
				else if (pixels_done != cfg_pixels)
					err_code = gld_pkg::ST_SHORT;
				else begin
					done = 1;
					w = {8'd0, gld_pkg::ST_END, 1'b1};
					return;
				end
			end else if (c < roots || c < nxt) begin
				ln = c < clr ? 1 : lens[c & 4095];
				if (pixels_done + ln > cfg_pixels)
					err_code = gld_pkg::ST_OVERFLOW;
				else begin
					unwind(c, fe);
					if (prev_ok && nxt < gld_pkg::TABLE_ENTRIES)
						add_entry(prev_code, stk[lvl - 1], clr);
				end
			end else if (!prev_ok)
				err_code = gld_pkg::ST_NO_PRIOR;
			else if (c != nxt)
				err_code = gld_pkg::ST_NOT_NEXT;
			else begin
				ln = (prev_code < clr ? 1 : lens[prev_code & 4095]) + 1;
				if (pixels_done + ln > cfg_pixels)
					err_code = gld_pkg::ST_OVERFLOW;
				else if (nxt >= gld_pkg::TABLE_ENTRIES)
					err_code = gld_pkg::ST_FULL;
				else begin
					ln = prev_code;
					n = 0;
					while (ln >= fe && n < gld_pkg::TABLE_ENTRIES) begin
						ln = pfx[ln & 4095];
						n++;
					end
					add_entry(prev_code, ln & 255, clr);
					unwind(c, fe);
				end
			end
			if (err_code != 0) begin
				failed = 1;
				w = {8'd0, 4'(err_code), 1'b1};
				return;
			end
			prev_code = c;
			prev_ok = 1;
		end
	endfunction

	// stream packing with the same width rule as the decoder
	int enc_cw, enc_next, pack_bits;
	bit enc_prev;
	logic [63:0] pack_acc;

	function automatic void emit_code(input int code);
		int clr;
		clr = 1 << cfg_min;
		if (enc_next >= (1 << enc_cw) && enc_cw < gld_pkg::MAX_WIDTH)
			enc_cw++;
		pack_acc |= 64'(code) << pack_bits;
		pack_bits += enc_cw;
		while (pack_bits >= 8) begin
			stream.push_back(pack_acc[7:0]);
			pack_acc >>= 8;
			pack_bits -= 8;
		end
		if (code == clr) begin
			enc_cw = cfg_min + 1;
			enc_next = clr + 2;
			enc_prev = 0;
		end else if (code != clr + 1) begin
			if (enc_prev && enc_next < gld_pkg::TABLE_ENTRIES)
				enc_next++;
			enc_prev = 1;
		end
	endfunction

	task automatic build_stream();
		int dict[int];
		int clr, nxt_code, cur, key, i;
		clr = 1 << cfg_min;
		for (i = 0; i < PIXELS; i++)
			pixels[i] = (i > 0 && $urandom_range(1)) ? pixels[i - 1] :
				$urandom_range((1 << cfg_color) - 1);
		enc_cw = cfg_min + 1;
		enc_next = clr + 2;
		enc_prev = 0;
		pack_acc = '0;
		pack_bits = 0;
		nxt_code = clr + 2;
		emit_code(clr);
		cur = pixels[0];
		for (i = 1; i < PIXELS; i++) begin
			key = cur * 256 + pixels[i];
			if (dict.exists(key))
				cur = dict[key];
			else begin
				emit_code(cur);
				if (nxt_code < gld_pkg::TABLE_ENTRIES)
					dict[key] = nxt_code++;
				cur = pixels[i];
				if ($urandom_range(299) == 0) begin
					emit_code(clr);
					dict.delete();
					nxt_code = clr + 2;
				end
			end
		end
		emit_code(cur);
		emit_code(clr + 1);
		if (pack_bits > 0)
			stream.push_back(pack_acc[7:0]);
	endtask

	task automatic send(input logic cmd, input logic [7:0] b, input logic fin,
		output bit has, output word_t w);
		@(negedge clk);
		while ((idle_mode == 1 && $urandom_range(99) < 51) ||
				(idle_mode == 3 && $urandom_range(99) < 32)) begin
			din.valid <= 1'b0;
			@(negedge clk);
		end
		din.valid <= 1'b1;
		din.command <= cmd;
		din.data_byte <= b;
		din.final_byte <= fin;
		do
			@(posedge clk);
		while (!din.ready);
		decode_step(cmd, b, fin, has, w);
		if (has)
			expected_words.push_back(w);
		accepted++;
		if (accepted % 200 == 0)
			idle_mode = (accepted / 200) % 4;
	endtask

	task automatic hold_input();
		@(negedge clk);
		din.valid <= 1'b0;
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		@(negedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= val;
		do
			@(posedge clk);
		while (!cfg.ready);
		config_write(idx, val);
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	task automatic run_rows(input row_t rows[$]);
		bit has;
		word_t w;
		foreach (rows[i]) begin
			send(rows[i].cmd, rows[i].b, rows[i].fin, has, w);
			if ((rows[i].chk == CHK_NONE && has) ||
					(rows[i].chk == CHK_STATUS &&
					(!has || w.st != rows[i].st || w.last != rows[i].last))) begin
				mismatches++;
				if (mismatches <= 10)
					$display("row %0d: expected status %0d last %0d, predicted %0d %0d",
						i, rows[i].st, rows[i].last, w.st, w.last);
			end
		end
		hold_input();
	endtask

	initial begin
		row_t head[$], tail[$];
		bit has;
		word_t w;
		int pos;
		din.valid = 1'b0;
		din.command = gld_pkg::CMD_PUSH;
		din.data_byte = '0;
		din.final_byte = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = gld_pkg::REG_MIN_CODE;
		cfg.data = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		write_reg(gld_pkg::REG_MIN_CODE, 11);
		write_reg(gld_pkg::REG_COLOR_BITS, 1);
		write_reg(gld_pkg::REG_PIXEL_COUNT, gld_pkg::MAX_PIXELS);
		write_reg(gld_pkg::REG_MIN_CODE, 1);
		write_reg(gld_pkg::REG_COLOR_BITS, 8);
		write_reg(gld_pkg::REG_PIXEL_COUNT, 2);
		write_reg(gld_pkg::REG_MIN_CODE, $urandom_range(2, 8));
		write_reg(gld_pkg::REG_COLOR_BITS, $urandom_range(1, cfg_min));
		write_reg(gld_pkg::REG_PIXEL_COUNT, PIXELS);
		build_stream();

		// first pull with no bits held starts decoding but yields nothing
		head.push_back('{gld_pkg::CMD_PULL, 8'hFF, 1'b0, CHK_NONE, gld_pkg::ST_PIXEL, 1'b0});
		head.push_back('{gld_pkg::CMD_PULL, 8'h00, 1'b1, CHK_NONE, gld_pkg::ST_PIXEL, 1'b0});
		run_rows(head);

		pos = 0;
		while (!done && !failed) begin
			if (accepted == 600) begin
				hold_input();
				while (expected_words.size() != 0)
					@(posedge clk);
				repeat (40) @(posedge clk);
				write_reg(gld_pkg::REG_PIXEL_COUNT, 32'hFFFF_FFFF);
			end
			if (pos < stream.size() && held + 8 <= gld_pkg::BIT_BUFFER_BITS) begin
				send(gld_pkg::CMD_PUSH, stream[pos], pos == stream.size() - 1, has, w);
				pos++;
			end else
				send(gld_pkg::CMD_PULL, 8'($urandom_range(255)), 1'($urandom_range(1)),
					has, w);
		end
		hold_input();

		// after end of image: pulls repeat end status, pushes are dropped
		tail.push_back('{gld_pkg::CMD_PULL, 8'h00, 1'b0, CHK_STATUS, gld_pkg::ST_END, 1'b1});
		tail.push_back('{gld_pkg::CMD_PUSH, 8'hA5, 1'b1, CHK_NONE, gld_pkg::ST_PIXEL, 1'b0});
		tail.push_back('{gld_pkg::CMD_PUSH, 8'h5A, 1'b0, CHK_NONE, gld_pkg::ST_PIXEL, 1'b0});
		tail.push_back('{gld_pkg::CMD_PULL, 8'hFF, 1'b1, CHK_STATUS, gld_pkg::ST_END, 1'b1});
		run_rows(tail);
		repeat (40) begin
			send(1'($urandom_range(1)), 8'($urandom_range(255)), 1'($urandom_range(1)),
				has, w);
		end
		hold_input();

		while (expected_words.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule
